>>> rtl/core/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg
// shared constants, types and command structs for the triangle tangent core
// ----------------------------------------------------------------------------
package tt_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int DELTA_WIDTH = COORD_WIDTH + 1;
   localparam int WIDE_WIDTH  = 2 * COORD_WIDTH + 3;
   localparam int DIV_WIDTH   = WIDE_WIDTH + FRAC_BITS;
   localparam int CNT_WIDTH   = $clog2(DIV_WIDTH + 1);
   localparam int MUL_SEL_WIDTH = 3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DET0,
      ST_MUL_DET1,
      ST_DET_CHECK,
      ST_MUL_NUM0,
      ST_MUL_NUM1,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DIV_DONE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic                     capture;
      logic                     mul_en;
      logic [MUL_SEL_WIDTH-1:0] mul_sel;
      logic [1:0]               comp;
      logic                     div_start;
      logic                     div_step;
      logic                     div_store;
      logic                     clear_clip;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
      logic div_last;
   } status_type;

   localparam logic [MUL_SEL_WIDTH-1:0] SEL_DU1_DV2 = 3'd0;
   localparam logic [MUL_SEL_WIDTH-1:0] SEL_DU2_DV1 = 3'd1;
   localparam logic [MUL_SEL_WIDTH-1:0] SEL_DV2_E1  = 3'd2;
   localparam logic [MUL_SEL_WIDTH-1:0] SEL_DV1_E2  = 3'd3;

endpackage

>>> rtl/core/tt_ctrl.sv
// ----------------------------------------------------------------------------
// tt_ctrl
// sequencer: vertex phase, multiply steps and the divider loop per component
// ----------------------------------------------------------------------------
module tt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                load_vertex,
   output logic [1:0]          phase,
   output tt_pkg::cmd_type     cmd,
   input  tt_pkg::status_type  status,
   output logic                rsp_load,
   output logic                rsp_degen
);

   tt_pkg::state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] comp_ff, comp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tt_pkg::ST_IDLE;
         phase_ff     <= 2'd0;
         comp_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign phase     = phase_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.comp     = comp_ff;
      req_ready    = 1'b0;
      load_vertex  = 1'b0;
      rsp_load     = 1'b0;
      rsp_degen    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         tt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               load_vertex = 1'b1;
               if (phase_ff == 2'd1) begin
                  phase_in = 2'd2;
               end else if (phase_ff == 2'd2) begin
                  phase_in    = 2'd0;
                  cmd.capture = 1'b1;
                  state_in    = tt_pkg::ST_MUL_DET0;
               end else begin
                  phase_in = 2'd1;
               end
            end
         end
         tt_pkg::ST_MUL_DET0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tt_pkg::SEL_DU1_DV2;
            state_in    = tt_pkg::ST_MUL_DET1;
         end
         tt_pkg::ST_MUL_DET1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tt_pkg::SEL_DU2_DV1;
            cmd.clear_clip = 1'b1;
            comp_in     = 2'd0;
            state_in    = tt_pkg::ST_DET_CHECK;
         end
         tt_pkg::ST_DET_CHECK: begin
            if (status.det_zero) begin
               state_in = tt_pkg::ST_OUTPUT;
            end else begin
               state_in = tt_pkg::ST_MUL_NUM0;
            end
         end
         tt_pkg::ST_MUL_NUM0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tt_pkg::SEL_DV2_E1;
            state_in    = tt_pkg::ST_MUL_NUM1;
         end
         tt_pkg::ST_MUL_NUM1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = tt_pkg::SEL_DV1_E2;
            state_in    = tt_pkg::ST_DIV_START;
         end
         tt_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = tt_pkg::ST_DIV_RUN;
         end
         tt_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = tt_pkg::ST_DIV_DONE;
            end
         end
         tt_pkg::ST_DIV_DONE: begin
            cmd.div_store = 1'b1;
            if (comp_ff == 2'd2) begin
               state_in = tt_pkg::ST_OUTPUT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = tt_pkg::ST_MUL_NUM0;
            end
         end
         tt_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_degen    = status.det_zero;
               rsp_valid_in = 1'b1;
               state_in     = tt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/tt_datapath.sv
// ----------------------------------------------------------------------------
// tt_datapath
// vertex holding, deltas, shared multiplier with accumulator, serial divider
// ----------------------------------------------------------------------------
module tt_datapath (
   input  logic                          clock,
   input  logic                          load_vertex,
   input  logic [1:0]                    phase,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [31:0]            req_pos_z,
   input  logic signed [31:0]            req_tex_u,
   input  logic signed [31:0]            req_tex_v,
   input  tt_pkg::cmd_type               cmd,
   output tt_pkg::status_type            status,
   input  logic                          rsp_load,
   input  logic                          rsp_degen,
   output logic signed [31:0]            rsp_tangent_x,
   output logic signed [31:0]            rsp_tangent_y,
   output logic signed [31:0]            rsp_tangent_z,
   output logic                          rsp_degenerate,
   output logic                          rsp_clipped
);

   localparam int CW = tt_pkg::COORD_WIDTH;
   localparam int DW = tt_pkg::DELTA_WIDTH;
   localparam int WW = tt_pkg::WIDE_WIDTH;
   localparam int VW = tt_pkg::DIV_WIDTH;
   localparam int NW = tt_pkg::CNT_WIDTH;

   logic signed [CW-1:0] pos_ff [6];
   logic signed [CW-1:0] tex_ff [4];
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [WW-1:0] det_ff, acc_ff;
   logic signed [DW-1:0] ma, mb;
   logic signed [2*DW-1:0] prod;
   logic signed [CW-1:0] in_pos [3];
   logic [VW-1:0] quo_ff, dvd_ff;
   logic [WW-1:0] rem_ff, dmag_ff;
   logic [WW:0]   rem_sh, trial;
   logic [NW-1:0] cnt_ff;
   logic          neg_ff, clip_ff;
   logic signed [CW-1:0] tan_ff [3];
   logic signed [CW-1:0] sat_val;
   logic          sat_clip;
   logic [WW-1:0] num_mag;
   logic [CW-1:0] limit;

   assign in_pos[0] = req_pos_x[CW-1:0];
   assign in_pos[1] = req_pos_y[CW-1:0];
   assign in_pos[2] = req_pos_z[CW-1:0];

   always_ff @(posedge clock) begin
      if (load_vertex && phase != 2'd2) begin
         for (int k = 0; k < 3; k++) begin
            pos_ff[(phase == 2'd1 ? 3 : 0) + k] <= in_pos[k];
         end
         tex_ff[phase == 2'd1 ? 2 : 0] <= req_tex_u[CW-1:0];
         tex_ff[phase == 2'd1 ? 3 : 1] <= req_tex_v[CW-1:0];
      end
      if (cmd.capture) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= DW'(pos_ff[3+k]) - DW'(pos_ff[k]);
            e2_ff[k] <= DW'(in_pos[k]) - DW'(pos_ff[k]);
         end
         du1_ff <= DW'(tex_ff[2]) - DW'(tex_ff[0]);
         dv1_ff <= DW'(tex_ff[3]) - DW'(tex_ff[1]);
         du2_ff <= DW'(signed'(req_tex_u[CW-1:0])) - DW'(tex_ff[0]);
         dv2_ff <= DW'(signed'(req_tex_v[CW-1:0])) - DW'(tex_ff[1]);
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         tt_pkg::SEL_DU1_DV2: begin ma = du1_ff; mb = dv2_ff; end
         tt_pkg::SEL_DU2_DV1: begin ma = du2_ff; mb = dv1_ff; end
         tt_pkg::SEL_DV2_E1:  begin ma = dv2_ff; mb = e1_ff[cmd.comp]; end
         tt_pkg::SEL_DV1_E2:  begin ma = dv1_ff; mb = e2_ff[cmd.comp]; end
         default:             begin ma = '0; mb = '0; end
      endcase
   end

   assign prod = ma * mb;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            tt_pkg::SEL_DU1_DV2, tt_pkg::SEL_DV2_E1: begin
               acc_ff <= WW'(prod);
            end
            default: begin
               acc_ff <= acc_ff - WW'(prod);
            end
         endcase
         if (cmd.mul_sel == tt_pkg::SEL_DU2_DV1) begin
            det_ff <= acc_ff - WW'(prod);
         end
      end
   end

   assign status.det_zero = (det_ff == '0);
   assign status.div_last = (cnt_ff == NW'(1));

   assign num_mag = acc_ff[WW-1] ? WW'(-acc_ff) : WW'(acc_ff);
   assign rem_sh  = {rem_ff, dvd_ff[VW-1]};
   assign trial   = rem_sh - {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff  <= {num_mag, {tt_pkg::FRAC_BITS{1'b0}}};
         dmag_ff <= det_ff[WW-1] ? WW'(-det_ff) : WW'(det_ff);
         neg_ff  <= acc_ff[WW-1] ^ det_ff[WW-1];
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= NW'(VW);
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[VW-2:0], 1'b0};
         cnt_ff <= cnt_ff - NW'(1);
         if (!trial[WW]) begin
            rem_ff <= trial[WW-1:0];
            quo_ff <= {quo_ff[VW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[WW-1:0];
            quo_ff <= {quo_ff[VW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      limit    = neg_ff ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      sat_clip = (quo_ff[VW-1:CW] != '0) || (quo_ff[CW-1:0] > limit);
      if (sat_clip) begin
         sat_val = neg_ff ? signed'(limit) : signed'(limit);
      end else begin
         sat_val = neg_ff ? -signed'(quo_ff[CW-1:0]) : signed'(quo_ff[CW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_clip) begin
         clip_ff <= 1'b0;
      end else if (cmd.div_store) begin
         clip_ff <= clip_ff | sat_clip;
      end
      if (cmd.div_store) begin
         tan_ff[cmd.comp] <= sat_val;
      end
      if (rsp_load) begin
         rsp_tangent_x  <= rsp_degen ? '0 : 32'(tan_ff[0]);
         rsp_tangent_y  <= rsp_degen ? '0 : 32'(tan_ff[1]);
         rsp_tangent_z  <= rsp_degen ? '0 : 32'(tan_ff[2]);
         rsp_degenerate <= rsp_degen;
         rsp_clipped    <= rsp_degen ? 1'b0 : clip_ff;
      end
   end

endmodule

>>> rtl/core/triangle_tangent_core.sv
// timing: the serial restoring divider, one quotient bit per cycle over 83 bits per
// component, dominates the work; a new triangle is accepted only once the previous
// result is loaded into the output register, and a result stall holds the core;
// the first two vertices of a triangle are only stored
// reset: synchronous, active high; clears the vertex phase, sequencer and
// result valid; held vertex data is written by each triangle before use
// ----------------------------------------------------------------------------
// triangle_tangent_core
// per-triangle tangent from positions and texture coordinates
// ----------------------------------------------------------------------------
module triangle_tangent_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_tangent_x,
   output logic signed [31:0] rsp_tangent_y,
   output logic signed [31:0] rsp_tangent_z,
   output logic               rsp_degenerate,
   output logic               rsp_clipped
);

   tt_pkg::cmd_type    cmd;
   tt_pkg::status_type status;
   logic       load_vertex, rsp_load, rsp_degen;
   logic [1:0] phase;

   tt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .load_vertex (load_vertex),
      .phase       (phase),
      .cmd         (cmd),
      .status      (status),
      .rsp_load    (rsp_load),
      .rsp_degen   (rsp_degen)
   );

   tt_datapath u_datapath (
      .clock          (clock),
      .load_vertex    (load_vertex),
      .phase          (phase),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_tex_u      (req_tex_u),
      .req_tex_v      (req_tex_v),
      .cmd            (cmd),
      .status         (status),
      .rsp_load       (rsp_load),
      .rsp_degen      (rsp_degen),
      .rsp_tangent_x  (rsp_tangent_x),
      .rsp_tangent_y  (rsp_tangent_y),
      .rsp_tangent_z  (rsp_tangent_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_clipped    (rsp_clipped)
   );

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_tangent_x == 0 && rsp_tangent_y == 0
         && rsp_tangent_z == 0 && !rsp_clipped)
      else $error("degenerate result with nonzero payload");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !req_ready)
      else $error("input taken while result being formed");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase != 2'd3)
      else $error("vertex phase out of range");
`endif

endmodule
